FILE: design/nclr_pkg.sv
// ----------------------------------------------------------------------------
// nclr_pkg
// shared types, codes and constants of the line renumberer
// ----------------------------------------------------------------------------
`default_nettype none

package nclr_pkg;

   localparam int COUNTER_DIGITS_DEFAULT = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 27;
   localparam int BIN_DIGITS = 9;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP = 2'd2;

   localparam logic MODE_N_PREFIX = 1'b0;
   localparam logic MODE_BARE_DIGITS = 1'b1;

   localparam logic [7:0] CHAR_N = 8'h4E;
   localparam logic [7:0] CHAR_NL = 8'h0A;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   // ten in bcd, reset value of start number and step
   localparam logic [7:0] BCD_TEN = 8'h10;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       head_v;
      logic       num_v;
      logic       tail_v;
      logic       reload;
   } cmd_type;

   typedef struct packed {
      logic start_load;
      logic update;
   } cfg_ctl_type;

   typedef enum logic [1:0] {
      LP_START  = 2'd0,
      LP_DIGITS = 2'd1,
      LP_REST   = 2'd2
   } line_phase_type;

   typedef enum logic [1:0] {
      BK_HEAD = 2'd0,
      BK_NUM  = 2'd1,
      BK_TAIL = 2'd2
   } back_step_type;

endpackage

`default_nettype wire

FILE: design/nc_line_renumberer_core.sv
// ----------------------------------------------------------------------------
// nc_line_renumberer_core
// rewrites line sequence numbers of a machine-tool program byte stream
// ----------------------------------------------------------------------------
// the first result of a byte passes the command queue, then the rsp register
// throughput: one byte per cycle while the queue has room and no register
//    write runs; a number goes out digit by digit, waiting for the registered
//    bcd counter sum if it was just updated; writes to start number or step
//    run a serial bcd conversion and an update, blocking req and csr transfers
// reset (synchronous): mode 0, start number 10, step 10, empty queue
`default_nettype none

module nc_line_renumberer_core #(
   parameter int COUNTER_DIGITS = nclr_pkg::COUNTER_DIGITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire nclr_pkg::req_payload_type        req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output nclr_pkg::rsp_payload_type             rsp_payload,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [nclr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [nclr_pkg::CSR_DATA_W-1:0]  csr_data
);
   import nclr_pkg::*;

   logic                        mode;
   logic [4*COUNTER_DIGITS-1:0] start_bcd;
   logic [4*COUNTER_DIGITS-1:0] step_bcd;
   cfg_ctl_type                 cfg_ctl;
   logic                        cfg_busy;
   logic                        push;
   cmd_type                     push_cmd;
   logic                        queue_full;
   logic                        pop;
   logic                        head_valid;
   cmd_type                     head_cmd;

   nclr_csr #(
      .COUNTER_DIGITS(COUNTER_DIGITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .mode      (mode),
      .start_bcd (start_bcd),
      .step_bcd  (step_bcd),
      .cfg_ctl   (cfg_ctl),
      .busy      (cfg_busy)
   );

   nclr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .mode        (mode),
      .queue_full  (queue_full),
      .cfg_busy    (cfg_busy),
      .push        (push),
      .cmd         (push_cmd)
   );

   nclr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   nclr_back #(
      .COUNTER_DIGITS(COUNTER_DIGITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (head_valid),
      .cmd         (head_cmd),
      .cmd_pop     (pop),
      .start_bcd   (start_bcd),
      .step_bcd    (step_bcd),
      .cfg_ctl     (cfg_ctl),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: design/nclr_csr.sv
// ----------------------------------------------------------------------------
// nclr_csr
// configuration registers with a serial binary to bcd converter
// ----------------------------------------------------------------------------
`default_nettype none

module nclr_csr #(
   parameter int COUNTER_DIGITS = nclr_pkg::COUNTER_DIGITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [nclr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [nclr_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                                    mode,
   output logic [4*COUNTER_DIGITS-1:0]             start_bcd,
   output logic [4*COUNTER_DIGITS-1:0]             step_bcd,
   output nclr_pkg::cfg_ctl_type                   cfg_ctl,
   output logic                                    busy
);
   import nclr_pkg::*;

   localparam int BCD_W = 4 * COUNTER_DIGITS;
   localparam int CONV_DIGITS = (COUNTER_DIGITS > BIN_DIGITS) ? COUNTER_DIGITS : BIN_DIGITS;
   localparam int CONV_W = 4 * CONV_DIGITS;
   localparam int CNT_W = $clog2(CSR_DATA_W + 1);

   logic                  mode_ff, mode_in;
   logic [BCD_W-1:0]      start_bcd_ff, start_bcd_in;
   logic [BCD_W-1:0]      step_bcd_ff, step_bcd_in;
   logic                  busy_ff, busy_in;
   logic                  target_start_ff, target_start_in;
   logic [CSR_DATA_W-1:0] bin_ff, bin_in;
   logic [CONV_W-1:0]     conv_ff, conv_in;
   logic [CONV_W-1:0]     adj;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  update_ff, update_in;
   logic                  start_load_ff, start_load_in;
   logic                  wr;

   assign csr_ready = !busy_ff && !update_ff;
   assign wr = csr_valid && csr_ready;

   always_comb begin
      for (int i = 0; i < CONV_DIGITS; i++) begin
         if (conv_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = conv_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = conv_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      mode_in = mode_ff;
      start_bcd_in = start_bcd_ff;
      step_bcd_in = step_bcd_ff;
      busy_in = busy_ff;
      target_start_in = target_start_ff;
      bin_in = bin_ff;
      conv_in = conv_ff;
      cnt_in = cnt_ff;
      update_in = 1'b0;
      start_load_in = 1'b0;
      if (busy_ff) begin
         conv_in = {adj[CONV_W-2:0], bin_ff[CSR_DATA_W-1]};
         bin_in = {bin_ff[CSR_DATA_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            update_in = 1'b1;
            if (target_start_ff) begin
               start_bcd_in = conv_in[BCD_W-1:0];
               start_load_in = 1'b1;
            end else begin
               step_bcd_in = conv_in[BCD_W-1:0];
            end
         end
      end else if (wr) begin
         case (csr_index)
            CSR_MODE: begin
               mode_in = csr_data[0];
            end
            CSR_START, CSR_STEP: begin
               busy_in = 1'b1;
               target_start_in = (csr_index == CSR_START);
               bin_in = csr_data;
               conv_in = '0;
               cnt_in = CNT_W'(CSR_DATA_W);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_N_PREFIX;
         start_bcd_ff <= BCD_W'(BCD_TEN);
         step_bcd_ff <= BCD_W'(BCD_TEN);
         busy_ff <= 1'b0;
         update_ff <= 1'b0;
         start_load_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         start_bcd_ff <= start_bcd_in;
         step_bcd_ff <= step_bcd_in;
         busy_ff <= busy_in;
         update_ff <= update_in;
         start_load_ff <= start_load_in;
      end
   end

   always_ff @(posedge clock) begin
      target_start_ff <= target_start_in;
      bin_ff <= bin_in;
      conv_ff <= conv_in;
      cnt_ff <= cnt_in;
   end

   assign mode = mode_ff;
   assign start_bcd = start_bcd_ff;
   assign step_bcd = step_bcd_ff;
   assign cfg_ctl.start_load = start_load_ff;
   assign cfg_ctl.update = update_ff;
   assign busy = busy_ff || update_ff;

endmodule

`default_nettype wire

FILE: design/nclr_front.sv
// ----------------------------------------------------------------------------
// nclr_front
// accepts text bytes, tracks the line phase and issues output commands
// ----------------------------------------------------------------------------
`default_nettype none

module nclr_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire nclr_pkg::req_payload_type req_payload,
   input  wire logic                      mode,
   input  wire logic                      queue_full,
   input  wire logic                      cfg_busy,
   output logic                           push,
   output nclr_pkg::cmd_type              cmd
);
   import nclr_pkg::*;

   line_phase_type phase_ff, phase_in;
   logic           pending_ff, pending_in;
   logic           accept;
   logic           is_dig;
   logic           is_nl;
   logic           num_now;
   logic           pend_after;
   line_phase_type rest_phase;

   assign req_ready = !queue_full && !cfg_busy;
   assign accept = req_valid && req_ready;

   always_comb begin
      is_dig = (req_payload.text_byte >= CHAR_ZERO) && (req_payload.text_byte <= CHAR_NINE);
      is_nl = (req_payload.text_byte == CHAR_NL);
      rest_phase = is_nl ? LP_START : LP_REST;
      cmd = '0;
      cmd.text_byte = req_payload.text_byte;
      cmd.reload = req_payload.end_of_text;
      num_now = 1'b0;
      pend_after = pending_ff;
      phase_in = phase_ff;
      case (phase_ff)
         LP_START: begin
            if (mode == MODE_N_PREFIX && req_payload.text_byte == CHAR_N) begin
               cmd.head_v = 1'b1;
               phase_in = LP_DIGITS;
               pend_after = 1'b1;
            end else if (mode == MODE_BARE_DIGITS && is_dig) begin
               phase_in = LP_DIGITS;
               pend_after = 1'b1;
            end else begin
               cmd.head_v = 1'b1;
               phase_in = rest_phase;
            end
         end
         LP_DIGITS: begin
            if (!is_dig) begin
               num_now = pending_ff;
               pend_after = 1'b0;
               cmd.tail_v = 1'b1;
               phase_in = rest_phase;
            end
         end
         default: begin
            cmd.head_v = 1'b1;
            phase_in = rest_phase;
         end
      endcase
      cmd.num_v = num_now || (req_payload.end_of_text && pend_after);
      pending_in = pend_after;
      if (req_payload.end_of_text) begin
         phase_in = LP_START;
         pending_in = 1'b0;
      end
      if (!accept) begin
         phase_in = phase_ff;
         pending_in = pending_ff;
      end
      push = accept && (cmd.head_v || cmd.num_v || cmd.tail_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= LP_START;
         pending_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pending_ff <= pending_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/nclr_queue.sv
// ----------------------------------------------------------------------------
// nclr_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module nclr_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire nclr_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output nclr_pkg::cmd_type      head_cmd
);
   import nclr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: design/nclr_back.sv
// ----------------------------------------------------------------------------
// nclr_back
// runs output commands: bytes, bcd sequence number digits, counter update
// ----------------------------------------------------------------------------
`default_nettype none

module nclr_back #(
   parameter int COUNTER_DIGITS = nclr_pkg::COUNTER_DIGITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          cmd_valid,
   input  wire nclr_pkg::cmd_type             cmd,
   output logic                               cmd_pop,
   input  wire logic [4*COUNTER_DIGITS-1:0]   start_bcd,
   input  wire logic [4*COUNTER_DIGITS-1:0]   step_bcd,
   input  wire nclr_pkg::cfg_ctl_type         cfg_ctl,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output nclr_pkg::rsp_payload_type          rsp_payload
);
   import nclr_pkg::*;

   localparam int BCD_W = 4 * COUNTER_DIGITS;
   localparam int LEN_W = $clog2(COUNTER_DIGITS + 1);
   localparam int IDX_W = $clog2(COUNTER_DIGITS);

   back_step_type   step_ff, step_in;
   back_step_type   eff;
   logic [BCD_W-1:0] counter_ff, counter_in;
   logic [BCD_W-1:0] sum_ff, sum_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             aux_valid_ff, aux_valid_in;
   logic [BCD_W-1:0] num_ff, num_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic             started_ff, started_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   logic [BCD_W-1:0] pre;
   logic [BCD_W:0]   raw;
   logic [BCD_W:0]   carries;
   logic             counter_wr;
   logic             out_free;
   logic             fire;
   logic             last;
   logic [7:0]       out_byte;
   logic [3:0]       digit;
   logic [LEN_W-1:0] remaining;
   logic [LEN_W-1:0] len_dec;
   logic [LEN_W-1:0] rem_dec;
   logic [3:0]       first_digit;
   logic [3:0]       next_digit;

   // counter plus step in bcd, and the digit count of the counter
   always_comb begin
      for (int i = 0; i < COUNTER_DIGITS; i++) begin
         pre[4*i +: 4] = counter_ff[4*i +: 4] + 4'd6;
      end
      raw = {1'b0, pre} + {1'b0, step_bcd};
      carries = raw ^ {1'b0, pre} ^ {1'b0, step_bcd};
      for (int i = 0; i < COUNTER_DIGITS; i++) begin
         if (carries[4*i+4]) begin
            sum_in[4*i +: 4] = raw[4*i +: 4];
         end else begin
            sum_in[4*i +: 4] = raw[4*i +: 4] - 4'd6;
         end
      end
      len_in = LEN_W'(1);
      for (int i = 0; i < COUNTER_DIGITS; i++) begin
         if (counter_ff[4*i +: 4] != 4'd0) begin
            len_in = LEN_W'(i + 1);
         end
      end
   end

   assign len_dec = len_ff - LEN_W'(1);
   assign rem_dec = rem_ff - LEN_W'(1);
   assign first_digit = counter_ff[{len_dec[IDX_W-1:0], 2'b00} +: 4];
   assign next_digit = num_ff[{rem_dec[IDX_W-1:0], 2'b00} +: 4];
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      eff = step_ff;
      if (eff == BK_HEAD && !cmd.head_v) begin
         eff = BK_NUM;
      end
      if (eff == BK_NUM && !cmd.num_v) begin
         eff = BK_TAIL;
      end
      fire = cmd_valid && out_free && !(eff == BK_NUM && !started_ff && !aux_valid_ff);

      step_in = step_ff;
      counter_in = counter_ff;
      counter_wr = 1'b0;
      num_in = num_ff;
      rem_in = rem_ff;
      started_in = started_ff;
      cmd_pop = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      out_byte = cmd.text_byte;
      digit = first_digit;
      remaining = len_dec;
      last = 1'b1;

      case (eff)
         BK_HEAD: begin
            last = !cmd.num_v && !cmd.tail_v;
         end
         BK_NUM: begin
            if (started_ff) begin
               digit = next_digit;
               remaining = rem_dec;
            end
            out_byte = CHAR_ZERO | {4'h0, digit};
            last = (remaining == '0) && !cmd.tail_v;
         end
         BK_TAIL: begin
            last = 1'b1;
         end
         default: begin
            last = 1'b1;
         end
      endcase

      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_payload_in.out_byte = out_byte;
         rsp_payload_in.last_of_run = last;
         case (eff)
            BK_HEAD: begin
               step_in = BK_NUM;
            end
            BK_NUM: begin
               if (!started_ff) begin
                  num_in = counter_ff;
                  counter_in = sum_ff;
                  counter_wr = 1'b1;
               end
               rem_in = remaining;
               started_in = (remaining != '0);
               if (remaining == '0) begin
                  step_in = BK_TAIL;
               end
            end
            default: begin
            end
         endcase
         if (last) begin
            cmd_pop = 1'b1;
            step_in = BK_HEAD;
            started_in = 1'b0;
            if (cmd.reload) begin
               counter_in = start_bcd;
               counter_wr = 1'b1;
            end
         end
      end

      if (cfg_ctl.start_load) begin
         counter_in = start_bcd;
         counter_wr = 1'b1;
      end
      aux_valid_in = !counter_wr && !cfg_ctl.update;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= BK_HEAD;
         counter_ff <= BCD_W'(BCD_TEN);
         aux_valid_ff <= 1'b0;
         started_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         counter_ff <= counter_in;
         aux_valid_ff <= aux_valid_in;
         started_ff <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      len_ff <= len_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the line renumberer: a directed table of bytes
// and register writes, then random machine-tool programs under several
// numbering settings, each output byte checked against the table or a predictor
// ----------------------------------------------------------------------------

module tb_top;

   import nclr_pkg::*;

   localparam int unsigned COUNT_MOD = 10 ** COUNTER_DIGITS_DEFAULT;
   localparam logic [26:0] TOP_NUMBER = 27'd99_999_999;
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam int RANDOM_BYTES = 150;
   localparam int PHASE_BYTES = 30;

   typedef struct {
      bit          is_write;
      logic [1:0]  reg_index;
      logic [26:0] reg_value;
      logic [7:0]  text_byte;
      bit          eot;
      bit          typed;
      string       text;
   } step_row_type;

   // reset settings: mode 0, start 10, step 10
   step_row_type steps_tab [29] = '{
      '{1'b0, CSR_MODE, 27'd0, CHAR_N, 1'b0, 1'b1, "N"},
      '{1'b0, CSR_MODE, 27'd0, "1", 1'b0, 1'b1, ""},
      '{1'b0, CSR_MODE, 27'd0, "9", 1'b0, 1'b1, ""},
      '{1'b0, CSR_MODE, 27'd0, CHAR_SPACE, 1'b0, 1'b1, "10 "},
      '{1'b0, CSR_MODE, 27'd0, "X", 1'b0, 1'b0, ""},
      '{1'b0, CSR_MODE, 27'd0, CHAR_NL, 1'b0, 1'b1, "\n"},
      '{1'b0, CSR_MODE, 27'd0, "5", 1'b0, 1'b1, "5"},
      '{1'b0, CSR_MODE, 27'd0, CHAR_CR, 1'b0, 1'b0, ""},
      '{1'b0, CSR_MODE, 27'd0, CHAR_NL, 1'b0, 1'b1, "\n"},
      '{1'b0, CSR_MODE, 27'd0, CHAR_N, 1'b0, 1'b1, "N"},
      '{1'b0, CSR_MODE, 27'd0, CHAR_NL, 1'b0, 1'b1, "20\n"},
      '{1'b0, CSR_MODE, 27'd0, CHAR_N, 1'b0, 1'b1, "N"},
      '{1'b0, CSR_MODE, 27'd0, "7", 1'b1, 1'b1, "30"},
      '{1'b0, CSR_MODE, 27'd0, 8'hFF, 1'b0, 1'b0, ""},
      '{1'b0, CSR_MODE, 27'd0, 8'h00, 1'b1, 1'b0, ""},
      '{1'b0, CSR_MODE, 27'd0, CHAR_N, 1'b1, 1'b1, "N10"},
      // upper data bits must be ignored by the mode register
      '{1'b1, CSR_MODE, 27'h7FF_FFFF, 8'h00, 1'b0, 1'b0, ""},
      '{1'b0, CSR_MODE, 27'd0, "4", 1'b0, 1'b1, ""},
      '{1'b0, CSR_MODE, 27'd0, "2", 1'b0, 1'b1, ""},
      '{1'b0, CSR_MODE, 27'd0, "G", 1'b0, 1'b1, "10G"},
      '{1'b0, CSR_MODE, 27'd0, CHAR_NL, 1'b0, 1'b1, "\n"},
      '{1'b0, CSR_MODE, 27'd0, CHAR_N, 1'b0, 1'b1, "N"},
      '{1'b0, CSR_MODE, 27'd0, CHAR_NL, 1'b0, 1'b1, "\n"},
      '{1'b0, CSR_MODE, 27'd0, "0", 1'b1, 1'b1, "20"},
      '{1'b1, CSR_START, TOP_NUMBER, 8'h00, 1'b0, 1'b0, ""},
      '{1'b1, CSR_STEP, 27'd1, 8'h00, 1'b0, 1'b0, ""},
      '{1'b0, CSR_MODE, 27'd0, "3", 1'b0, 1'b1, ""},
      '{1'b0, CSR_MODE, 27'd0, CHAR_NL, 1'b0, 1'b1, "99999999\n"},
      '{1'b0, CSR_MODE, 27'd0, "8", 1'b1, 1'b1, "0"}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // predictor state and settings
   logic           mode_now;
   logic [26:0]    start_now;
   logic [26:0]    step_now;
   line_phase_type phase_now;
   int unsigned    count_now;
   logic           pending_now;

   rsp_payload_type fresh_q[$];
   rsp_payload_type rewritten_q[$];
   logic [7:0]      prog_q[$];

   int  row_sel = -1;
   bit  gaps_on = 1'b1;
   bit  stalls_on = 1'b1;
   int  fails = 0;
   int  bytes_in = 0;
   int  results_out = 0;
   int  numbers_done = 0;
   int  settings_done = 0;

   nc_line_renumberer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= !stalls_on || ($urandom_range(0, 99) >= 29);
   end

   function automatic void add_out(input logic [7:0] b);
      rsp_payload_type r;
      r.out_byte = b;
      r.last_of_run = 1'b0;
      fresh_q.insert(fresh_q.size(), r);
   endfunction

   function automatic void write_count();
      logic [7:0]  digs [COUNTER_DIGITS_DEFAULT];
      int unsigned v;
      int          nd;
      v = count_now;
      nd = 0;
      do begin
         digs[nd] = CHAR_ZERO + 8'(v % 10);
         v = v / 10;
         nd++;
      end while (v != 0);
      for (int i = nd - 1; i >= 0; i--) add_out(digs[i]);
      count_now = (count_now + (32'(step_now) % COUNT_MOD)) % COUNT_MOD;
      pending_now = 1'b0;
      numbers_done++;
   endfunction

   function automatic void renumber_byte(input req_payload_type p);
      logic [7:0]      b;
      logic            is_dig;
      fresh_q.delete();
      b = p.text_byte;
      is_dig = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      case (phase_now)
         LP_START: begin
            if (mode_now == MODE_N_PREFIX && b == CHAR_N) begin
               add_out(b);
               phase_now = LP_DIGITS;
               pending_now = 1'b1;
            end else if (mode_now == MODE_BARE_DIGITS && is_dig) begin
               phase_now = LP_DIGITS;
               pending_now = 1'b1;
            end else begin
               add_out(b);
               phase_now = (b == CHAR_NL) ? LP_START : LP_REST;
            end
         end
         LP_DIGITS: begin
            if (!is_dig) begin
               if (pending_now) write_count();
               add_out(b);
               phase_now = (b == CHAR_NL) ? LP_START : LP_REST;
            end
         end
         default: begin
            add_out(b);
            phase_now = (b == CHAR_NL) ? LP_START : LP_REST;
         end
      endcase
      if (p.end_of_text) begin
         if (pending_now) write_count();
         phase_now = LP_START;
         pending_now = 1'b0;
         count_now = 32'(start_now) % COUNT_MOD;
      end
      if (fresh_q.size() > 0) begin
         fresh_q[fresh_q.size() - 1].last_of_run = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      string           txt;
      if (!reset && req_valid && req_ready) begin
         renumber_byte(req_payload);
         bytes_in++;
         if (row_sel >= 0 && steps_tab[row_sel].typed) begin
            txt = steps_tab[row_sel].text;
            for (int i = 0; i < txt.len(); i++) begin
               want.out_byte = txt[i];
               want.last_of_run = (i == txt.len() - 1);
               rewritten_q.insert(rewritten_q.size(), want);
            end
         end else begin
            foreach (fresh_q[i]) rewritten_q.insert(rewritten_q.size(), fresh_q[i]);
         end
      end
      if (!reset && rsp_valid && rsp_ready) begin
         results_out++;
         if (rewritten_q.size() == 0) begin
            $error("transfer with nothing expected: out_byte %h", rsp_payload.out_byte);
            fails++;
         end else begin
            want = rewritten_q.pop_front();
            if (rsp_payload.out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_payload.out_byte);
               fails++;
            end
            if (rsp_payload.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %b, got %b",
                      want.last_of_run, rsp_payload.last_of_run);
               fails++;
            end
         end
      end
   end

   task automatic push_byte(input req_payload_type p, input int row);
      req_valid <= 1'b1;
      req_payload <= p;
      row_sel <= row;
      do @(posedge clock); while (!req_ready);
      if (gaps_on && $urandom_range(0, 99) < 29) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [26:0] val, input bit keep);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (!keep) csr_valid <= 1'b0;
      case (idx)
         CSR_MODE: mode_now = val[0];
         CSR_START: begin
            start_now = val;
            count_now = 32'(val) % COUNT_MOD;
         end
         CSR_STEP: step_now = val;
         default: ;
      endcase
      settings_done++;
   endtask

   // wait for every owed result, then for the tail of any digit run in flight
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (rewritten_q.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (rewritten_q.size() != 0) begin
         $error("%0d expected results never arrived", rewritten_q.size());
         fails++;
         rewritten_q.delete();
      end
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [7:0] text_char();
      case ($urandom_range(0, 5))
         0: return CHAR_ZERO + 8'($urandom_range(0, 9));
         1: return CHAR_SPACE;
         2: return CHAR_CR;
         default: return CHAR_A + 8'($urandom_range(0, 25));
      endcase
   endfunction

   function automatic void add_head(input bit n_head, input int n_dig);
      if (n_head) prog_q.insert(prog_q.size(), CHAR_N);
      repeat (n_dig) prog_q.insert(prog_q.size(), CHAR_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void add_rest(input int n);
      repeat (n) prog_q.insert(prog_q.size(), text_char());
   endfunction

   function automatic logic [26:0] pick_number();
      case ($urandom_range(0, 4))
         0: return 27'd0;
         1: return TOP_NUMBER;
         2: return '1;
         3: return 27'($urandom_range(0, 999));
         default: return 27'($urandom_range(0, 99_999_999));
      endcase
   endfunction

   initial begin
      int  random_bytes;
      int  phase_bytes;
      int  phase_no;
      int  n_lines;
      int  pick;
      int  n_dig;
      bit  n_head;
      bit  keep;
      logic       set_mode;
      logic [26:0] set_start;
      logic [26:0] set_step;
      req_payload_type p;

      mode_now = MODE_N_PREFIX;
      start_now = 27'd10;
      step_now = 27'd10;
      phase_now = LP_START;
      count_now = 10;
      pending_now = 1'b0;
      random_bytes = 0;
      phase_no = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < $size(steps_tab); r++) begin
         if (steps_tab[r].is_write) begin
            if (r == 0 || !steps_tab[r - 1].is_write) drain();
            keep = (r + 1 < $size(steps_tab)) && steps_tab[r + 1].is_write;
            write_reg(steps_tab[r].reg_index, steps_tab[r].reg_value, keep);
         end else begin
            p.text_byte = steps_tab[r].text_byte;
            p.end_of_text = steps_tab[r].eot;
            push_byte(p, r);
         end
      end

      while (random_bytes < RANDOM_BYTES) begin
         drain();
         case (phase_no)
            0: begin
               set_mode = MODE_N_PREFIX;
               set_start = 27'd0;
               set_step = TOP_NUMBER;
            end
            1: begin
               set_mode = MODE_BARE_DIGITS;
               set_start = TOP_NUMBER;
               set_step = '1;
            end
            2: begin
               set_mode = MODE_N_PREFIX;
               set_start = '1;
               set_step = 27'd0;
            end
            default: begin
               set_mode = $urandom_range(0, 1) ? MODE_BARE_DIGITS : MODE_N_PREFIX;
               set_start = pick_number();
               set_step = ($urandom_range(0, 3) == 0) ? 27'd1 : pick_number();
            end
         endcase
         // one stretch with neither side idling
         gaps_on = (phase_no != 2);
         stalls_on = (phase_no != 2);
         write_reg(CSR_MODE, {26'($urandom), set_mode}, 1'b1);
         write_reg(CSR_START, set_start, 1'b1);
         write_reg(CSR_STEP, set_step, 1'b0);

         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            prog_q.delete();
            n_lines = $urandom_range(1, 4);
            for (int l = 0; l < n_lines; l++) begin
               pick = $urandom_range(0, 9);
               if (pick <= 6) begin
                  // mostly lines numbered the way the mode expects
                  n_head = (mode_now == MODE_N_PREFIX) ^ (pick == 6);
                  n_dig = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 11)
                                                      : $urandom_range(n_head ? 0 : 1, 4);
                  add_head(n_head, n_dig);
                  add_rest($urandom_range(0, 6));
               end else if (pick == 7) begin
                  add_rest($urandom_range(0, 6));
               end else if (pick == 8) begin
                  repeat ($urandom_range(1, 5))
                     prog_q.insert(prog_q.size(), 8'($urandom_range(0, 255)));
               end else begin
                  n_head = $urandom_range(0, 1);
                  add_head(n_head, n_head ? 0 : 1);
               end
               prog_q.insert(prog_q.size(), CHAR_NL);
            end
            n_head = (mode_now == MODE_N_PREFIX);
            case ($urandom_range(0, 3))
               1: add_head(n_head, $urandom_range(n_head ? 0 : 1, 3));
               2: add_rest($urandom_range(1, 3));
               3: begin
                  add_head(n_head, $urandom_range(n_head ? 0 : 1, 3));
                  prog_q.insert(prog_q.size(), CHAR_SPACE);
               end
               default: ;
            endcase
            foreach (prog_q[i]) begin
               p.text_byte = prog_q[i];
               p.end_of_text = (i == prog_q.size() - 1);
               push_byte(p, -1);
               phase_bytes++;
            end
         end
         random_bytes += phase_bytes;
         phase_no++;
      end

      gaps_on = 1'b1;
      stalls_on = 1'b1;
      drain();

      $display("renumbered %0d input bytes over %0d register writes, %0d numbers inserted",
               bytes_in, settings_done, numbers_done);
      $display("%0d output transfers compared, %0d mismatches", results_out, fails);
      if (fails == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
